>>> hw/rtl/lpcp_pkg.sv
`timescale 1ns / 1ps

package lpcp_pkg;

    // Palette capacity requested; the stored depth is capped at 16 (4-bit index)
    localparam int MAX_COLORS = 16;
    localparam int DEPTH      = (MAX_COLORS < 16) ? MAX_COLORS : 16;

    localparam int CMD_W     = 8;
    localparam int ANIM_W    = 8;
    localparam int SIZE_W    = 5;
    localparam int IDX_W     = 4;
    localparam int COLOUR_W  = 24;
    localparam int PAL_SLOTS = 16;
    localparam int OUT_W     = 48;   // 41 packed bits, padded to whole bytes
    localparam int USER_W    = 2;

    localparam logic [ANIM_W-1:0] ANIM_NONE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_END    = 2'b00,
        CMD_START  = 2'b01,
        CMD_PUSH   = 2'b10,
        CMD_COMMIT = 2'b11
    } t_cmd;

    // controller -> datapath
    typedef struct packed {
        logic take;      // input beat accepted
        logic rd_en;     // fetch palette entry at current index
        logic advance;   // result beat taken, more to follow
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_end;    // byte on the input is an end command
        logic last;      // current index is the final result of the run
    } t_dp_stat;

endpackage

>>> hw/rtl/led_palette_command_parser_unit.sv
`timescale 1ns / 1ps

// LED palette command parser. One command byte per input beat: bits 7:6 pick
// end (00), start (01), push (10) or commit (11); bits 5:0 are payload. Start
// opens a transaction with a new animation id, push shifts six bits into a
// 24-bit draft colour, commit shifts in six more and stores the draft in a
// 16-entry palette RAM (commits beyond the capacity are dropped and flagged).
// An end byte snapshots and clears the transaction, then streams one result
// beat per stored colour (one beat with color_present low if the palette is
// empty), tlast on the final beat. Start, push and commit bytes are taken as
// they arrive. An end byte is accepted, then each result is a palette RAM
// read followed by the output beat, which waits out any output stall; no
// input is taken while a run is streaming.
module led_palette_command_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_tdata: [7:0] cmd_byte
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpcp_pkg::CMD_W-1:0]    s_tdata,
    // m_tdata: [7:0] anim_id, [12:8] palette_size, [16:13] color_index,
    //          [40:17] color_value, [47:41] zero
    // m_tuser: [0] color_present, [1] overflowed
    // m_tlast: last_result
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpcp_pkg::OUT_W-1:0]    m_tdata,
    output logic [lpcp_pkg::USER_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import lpcp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: accept, palette fetch, result beat
    lpcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // transaction state, palette RAM and result formatting
    lpcp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (s_tdata),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_data  (m_tdata),
        .o_user  (m_tuser)
    );

    // final beat of the run
    assign m_tlast = dp_stat.last;

endmodule

>>> hw/rtl/lpcp_ram.sv
`timescale 1ns / 1ps

module lpcp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lpcp_ctrl.sv
`timescale 1ns / 1ps

module lpcp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  lpcp_pkg::t_dp_stat  i_stat,
    output lpcp_pkg::t_dp_cmd   o_cmd
);
    import lpcp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   s_take;
    logic   m_take;

    assign s_take = (r_state == ST_IDLE) && i_s_tvalid;
    assign m_take = (r_state == ST_SEND) && i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_stat.is_end) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (i_m_tready) n_state = i_stat.last ? ST_IDLE : ST_READ;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready    = (r_state == ST_IDLE);
    assign o_m_tvalid    = (r_state == ST_SEND);
    assign o_cmd.take    = s_take;
    assign o_cmd.rd_en   = (r_state == ST_READ);
    assign o_cmd.advance = m_take && !i_stat.last;

endmodule

>>> hw/rtl/lpcp_dp.sv
`timescale 1ns / 1ps

module lpcp_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lpcp_pkg::CMD_W-1:0]    i_byte,
    input  lpcp_pkg::t_dp_cmd             i_cmd,
    output lpcp_pkg::t_dp_stat            o_stat,
    output logic [lpcp_pkg::OUT_W-1:0]    o_data,
    output logic [lpcp_pkg::USER_W-1:0]   o_user
);
    import lpcp_pkg::*;

    localparam logic [SIZE_W-1:0] DEPTH_CNT = SIZE_W'(DEPTH);

    logic [ANIM_W-1:0]   r_anim;
    logic [COLOUR_W-1:0] r_draft;
    logic [SIZE_W-1:0]   r_count;
    logic                r_drop;

    // run snapshot, held while the results stream out
    logic [ANIM_W-1:0]   r_snap_anim;
    logic [SIZE_W-1:0]   r_snap_cnt;
    logic                r_snap_drop;
    logic [IDX_W-1:0]    r_idx;

    t_cmd                cmd;
    logic [COLOUR_W-1:0] draft_sh;
    logic                wr_en;
    logic                present;
    logic [COLOUR_W-1:0] rd_data;
    logic [COLOUR_W-1:0] colour;

    assign cmd      = t_cmd'(i_byte[7:6]);
    assign draft_sh = {r_draft[COLOUR_W-7:0], i_byte[5:0]};
    assign wr_en    = i_cmd.take && (cmd == CMD_COMMIT) && (r_count < DEPTH_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim  <= ANIM_NONE;
            r_draft <= '0;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.take) begin
            unique case (cmd)
                CMD_START: begin
                    r_anim  <= {1'b0, i_byte[5:3], 1'b0, i_byte[2:0]};
                    r_draft <= '0;
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
                CMD_PUSH: begin
                    r_draft <= draft_sh;
                end
                CMD_COMMIT: begin
                    r_draft <= '0;
                    if (r_count < DEPTH_CNT) begin
                        r_count <= r_count + SIZE_W'(1);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                CMD_END: begin
                    r_anim  <= ANIM_NONE;
                    r_draft <= '0;
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (cmd == CMD_END)) begin
            r_snap_anim <= r_anim;
            r_snap_cnt  <= r_count;
            r_snap_drop <= r_drop;
            r_idx       <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    lpcp_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PAL_SLOTS)
    ) u_pal (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (draft_sh),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign present       = (r_snap_cnt != '0);
    assign colour        = present ? rd_data : '0;
    assign o_stat.is_end = (cmd == CMD_END);
    // empty palette gives a single result
    assign o_stat.last   = (r_snap_cnt <= ({1'b0, r_idx} + SIZE_W'(1)));

    assign o_data = {7'd0, colour, r_idx, r_snap_cnt, r_snap_anim};
    assign o_user = {r_snap_drop, present};

endmodule

>>> bench/led_palette_command_parser_unit_tb.sv
`timescale 1ns / 1ps

// Bench for the LED palette command parser.
// Command bytes go in on the slave stream from a queue filled at time zero; each
// accepted byte is run through a local model of the parser, which queues the
// result beats that an end byte should give. The monitor takes result beats
// off the master stream and compares every field with the oldest queued beat.
module led_palette_command_parser_unit_tb;

    import lpcp_pkg::*;

    // Pending command byte; wait_drain holds it back until every queued
    // result beat has been seen.
    typedef struct packed {
        logic [CMD_W-1:0] cmd_byte;
        logic             wait_drain;
    } t_cmd_item;

    // One result beat as the parser should emit it
    typedef struct packed {
        logic [ANIM_W-1:0]   anim;
        logic [SIZE_W-1:0]   size;
        logic [IDX_W-1:0]    idx;
        logic [COLOUR_W-1:0] colour;
        logic                present;
        logic                dropped;
        logic                last;
    } t_palette_beat;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CMD_W-1:0]    s_tdata  = '0;   // [7:0] cmd_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;         // [7:0] anim_id, [12:8] palette_size,
                                          // [16:13] color_index, [40:17] color_value,
                                          // [47:41] zero
    logic [USER_W-1:0]   m_tuser;         // [0] color_present, [1] overflowed
    logic                m_tlast;         // last_result

    led_palette_command_parser_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expected results
    t_cmd_item     cmd_q[$];
    t_palette_beat run_beats_q[$];

    // Parser state as the bench sees it
    logic [ANIM_W-1:0]   cur_anim    = ANIM_NONE;
    logic [COLOUR_W-1:0] cur_draft   = '0;
    logic [COLOUR_W-1:0] colours [PAL_SLOTS];
    logic [SIZE_W-1:0]   cur_count   = '0;
    logic                cur_dropped = 1'b0;

    // Bookkeeping
    int unsigned n_queued    = 0;
    int unsigned bytes_taken = 0;
    int unsigned beats_seen  = 0;
    int unsigned ovf_beats   = 0;
    int unsigned widest_run  = 0;
    int unsigned n_start = 0, n_push = 0, n_commit = 0, n_end = 0;
    int unsigned errors  = 0;

    // Idle pacing for both sides
    int unsigned send_gap  = 0, send_calm = 0;
    int unsigned recv_gap  = 0, recv_calm = 0;
    int unsigned hold_left = 0;
    t_palette_beat want;

    function automatic logic [CMD_W-1:0] cmd_byte_of(t_cmd op, logic [5:0] payload);
        return {op, payload};
    endfunction

    function automatic void queue_byte(logic [CMD_W-1:0] b, logic drain);
        t_cmd_item item;
        item.cmd_byte   = b;
        item.wait_drain = drain;
        cmd_q.push_back(item);
        n_queued++;
    endfunction

    // Mostly no idle, often a short one, now and then a long one. A calm
    // stretch suppresses idling altogether for a while.
    function automatic int unsigned next_idle(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0)
            calm = $urandom_range(40, 120);
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one accepted command byte to the local parser state and queues
    // the result beats of an end byte.
    function automatic void parse_cmd_byte(logic [CMD_W-1:0] b);
        t_cmd          op;
        t_palette_beat beat;
        int unsigned   runs;
        int unsigned   k;
        op = t_cmd'(b[7:6]);
        case (op)
            CMD_START: begin
                // id bits 5:3 move up to 6:4, bits 2:0 stay
                cur_anim    = {1'b0, b[5:3], 1'b0, b[2:0]};
                cur_count   = '0;
                cur_draft   = '0;
                cur_dropped = 1'b0;
                n_start++;
            end
            CMD_PUSH: begin
                cur_draft = {cur_draft[COLOUR_W-7:0], b[5:0]};
                n_push++;
            end
            CMD_COMMIT: begin
                cur_draft = {cur_draft[COLOUR_W-7:0], b[5:0]};
                if (cur_count < SIZE_W'(DEPTH)) begin
                    colours[cur_count[IDX_W-1:0]] = cur_draft;
                    cur_count++;
                end else begin
                    cur_dropped = 1'b1;
                end
                cur_draft = '0;
                n_commit++;
            end
            default: begin
                // empty palette still gives one beat, colour marked absent
                runs = (cur_count == '0) ? 32'd1 : 32'(cur_count);
                for (k = 0; k < runs; k++) begin
                    beat.anim    = cur_anim;
                    beat.size    = cur_count;
                    beat.idx     = (cur_count == '0) ? '0 : k[IDX_W-1:0];
                    beat.colour  = (cur_count == '0) ? '0 : colours[k[IDX_W-1:0]];
                    beat.present = (cur_count != '0);
                    beat.dropped = cur_dropped;
                    beat.last    = (k + 1 == runs);
                    run_beats_q.push_back(beat);
                end
                if (runs > widest_run)
                    widest_run = runs;
                cur_anim    = ANIM_NONE;
                cur_count   = '0;
                cur_draft   = '0;
                cur_dropped = 1'b0;
                n_end++;
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Driver: offers the head of cmd_q, holds it until taken, then idles for
    // a random gap. A byte flagged wait_drain waits for the output to empty.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_cmd_byte(s_tdata);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() == 0 ||
                             (cmd_q[0].wait_drain && run_beats_q.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= cmd_q[0].cmd_byte;
                    s_tvalid <= 1'b1;
                    cmd_q.delete(0);
                    send_gap = next_idle(send_calm);
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest expectation and
    // paces m_tready with random stalls and the odd long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (run_beats_q.size() == 0) begin
                    $error("result beat 0x%0h arrived with none expected", m_tdata);
                    errors++;
                end else begin
                    want = run_beats_q.pop_front();
                    if (want.dropped)
                        ovf_beats++;
                    check_field("anim_id",       32'(want.anim),    32'(m_tdata[7:0]));
                    check_field("palette_size",  32'(want.size),    32'(m_tdata[12:8]));
                    check_field("color_index",   32'(want.idx),     32'(m_tdata[16:13]));
                    check_field("color_value",   32'(want.colour),  32'(m_tdata[40:17]));
                    check_field("tdata padding", 32'd0,             32'(m_tdata[47:41]));
                    check_field("color_present", 32'(want.present), 32'(m_tuser[0]));
                    check_field("overflowed",    32'(want.dropped), 32'(m_tuser[1]));
                    check_field("last_result",   32'(want.last),    32'(m_tlast));
                end
                // one guaranteed long back-pressure stretch while bytes keep coming
                if (beats_seen == 30)
                    hold_left = 120;
            end
            if (hold_left == 0 && $urandom_range(0, 399) == 0)
                hold_left = $urandom_range(50, 100);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = next_idle(recv_calm);
            end
        end
    end

    initial begin
        int unsigned i, c, n_col, roll;
        logic        drain;

        // Directed: end straight out of reset (no animation, empty palette)
        queue_byte(cmd_byte_of(CMD_END, 6'h00), 1'b0);
        // pushes and a commit with no transaction open; the fifth shift
        // pushes the oldest draft bits off the top
        repeat (4) queue_byte(cmd_byte_of(CMD_PUSH, 6'h3F), 1'b0);
        queue_byte(cmd_byte_of(CMD_COMMIT, 6'h00), 1'b0);
        // end without start, one colour
        queue_byte(cmd_byte_of(CMD_END, 6'h3F), 1'b0);
        // full palette plus one dropped commit
        queue_byte(cmd_byte_of(CMD_START, 6'h3F), 1'b0);
        for (i = 0; i < DEPTH + 1; i++)
            queue_byte(cmd_byte_of(CMD_COMMIT, (i == DEPTH - 1) ? 6'h3F : 6'(i * 3)), 1'b0);
        queue_byte(cmd_byte_of(CMD_END, 6'h15), 1'b0);

        // Random: mostly well-formed transactions, some stray bytes
        drain = 1'b1;   // first random byte waits for the directed runs to drain
        while (n_queued < 230) begin
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
                queue_byte(cmd_byte_of(CMD_START, 6'($urandom_range(0, 63))), drain);
                n_col = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19)
                                                    : $urandom_range(0, 5);
                for (c = 0; c < n_col; c++) begin
                    repeat ($urandom_range(0, 4))
                        queue_byte(cmd_byte_of(CMD_PUSH, 6'($urandom_range(0, 63))), 1'b0);
                    queue_byte(cmd_byte_of(CMD_COMMIT, 6'($urandom_range(0, 63))), 1'b0);
                end
                queue_byte(cmd_byte_of(CMD_END, 6'($urandom_range(0, 63))), 1'b0);
            end else begin
                queue_byte(CMD_W'($urandom_range(0, 255)), drain);
            end
            drain = ($urandom_range(0, 15) == 0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != n_queued || run_beats_q.size() != 0)
            @(posedge i_clk);
        // idle on so that a stray beat after the last one would still be caught
        repeat (20) @(posedge i_clk);

        $display("Sent %0d command bytes: %0d start, %0d push, %0d commit, %0d end.",
                 bytes_taken, n_start, n_push, n_commit, n_end);
        $display("Checked %0d result beats (%0d flagged overflow), widest run %0d beats.",
                 beats_seen, ovf_beats, widest_run);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
